>>> rtl/depth_window_threshold_macros.svh
// Assertion macros for the depth window threshold block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef DEPTH_WINDOW_THRESHOLD_MACROS_SVH
`define DEPTH_WINDOW_THRESHOLD_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define DWT_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define DWT_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DWT_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dwt_pkg.sv
`default_nettype none

package dwt_pkg;

	// Image geometry and confidence floor.
	localparam int IMG_WIDTH      = 320;
	localparam int IMG_HEIGHT     = 240;
	localparam int MIN_CONFIDENCE = 0;

	// Field widths.
	localparam int CNT_W   = 10;
	localparam int DEPTH_W = 16;
	localparam int CONF_W  = 16;
	localparam int GREY_W  = 8;
	localparam int CFG_W   = 16;

	// Grey shading constants.
	localparam int GREY_TOP  = 255;
	localparam int GREY_STEP = 10;

	// Register reset values.
	localparam logic [DEPTH_W-1:0] BACK_LIMIT_RST = DEPTH_W'(4000);
	localparam logic [CNT_W-1:0]   CROP_MAX_RST   = CNT_W'(1023);

	// Far limit interpolation: numerator below 2^FAR_NUM_W, divided by IMG_HEIGHT
	// through an exact reciprocal multiply.
	localparam int FAR_NUM_W   = DEPTH_W + $clog2(IMG_HEIGHT);
	localparam int FAR_SH      = FAR_NUM_W + $clog2(IMG_HEIGHT);
	localparam int FAR_RECIP_W = FAR_NUM_W + 2;
	localparam int FAR_PROD_W  = FAR_NUM_W + FAR_RECIP_W;
	localparam logic [FAR_RECIP_W-1:0] FAR_RECIP = FAR_RECIP_W'(
		((64'd1 << FAR_SH) + 64'(IMG_HEIGHT) - 64'd1) / 64'(IMG_HEIGHT));

	// Signed working width for the interpolation numerator.
	localparam int NUM_W   = DEPTH_W + CNT_W + 2;
	localparam int SLOPE_W = DEPTH_W + CNT_W + 1;

	// Grey divide by GREY_STEP on a 16-bit magnitude.
	localparam int GREY_SH      = DEPTH_W + $clog2(GREY_STEP);
	localparam int GREY_RECIP_W = DEPTH_W + 2;
	localparam int GREY_PROD_W  = DEPTH_W + GREY_RECIP_W;
	localparam logic [GREY_RECIP_W-1:0] GREY_RECIP = GREY_RECIP_W'(
		((64'd1 << GREY_SH) + 64'(GREY_STEP) - 64'd1) / 64'(GREY_STEP));

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_SHOW_RAW       = 3'd0,
		REG_FRONT_LIMIT    = 3'd1,
		REG_BACK_AT_TOP    = 3'd2,
		REG_BACK_AT_BOTTOM = 3'd3,
		REG_CROP_LEFT      = 3'd4,
		REG_CROP_RIGHT     = 3'd5,
		REG_CROP_TOP       = 3'd6,
		REG_CROP_BOTTOM    = 3'd7
	} cfg_reg_t;

	// One input pixel.
	typedef struct packed {
		logic [DEPTH_W-1:0] depth_value;
		logic [CONF_W-1:0]  conf_value;
	} pix_t;

	// One result pixel.
	typedef struct packed {
		logic [DEPTH_W-1:0] depth_out;
		logic [GREY_W-1:0]  grey_level;
		logic               mask_on;
		logic               frame_end;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/depth_window_threshold.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// pix       in         pix_valid / pix_ready   dwt_pkg::pix_t (depth_value, conf_value)
// res       out        res_valid / res_ready   dwt_pkg::res_t (depth_out, grey_level,
//                                              mask_on, frame_end)
// cfg       in         cfg_we                  cfg_index, cfg_data
//
// One item is accepted per cycle while res_ready does not stall the pipeline; each result
// passes through the input, far limit product, decision, divide-by-ten product and output registers.
// The far limit reciprocal multiply and the divide-by-ten reciprocal multiply are
// each followed by its own register.
// Reset clears the counters, the stage valid bits and sets the registers to defaults.
// A stage holds its item only while the next stage is full and stalled, so ready
// stays high as long as any bubble is left in the pipeline.

module depth_window_threshold (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pix_valid,
	output logic                 pix_ready,
	input  wire dwt_pkg::pix_t   pix,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output dwt_pkg::res_t        res,
	input  wire logic            cfg_we,
	input  wire dwt_pkg::cfg_reg_t cfg_index,
	input  wire logic [dwt_pkg::CFG_W-1:0] cfg_data
);
	import dwt_pkg::*;

	localparam logic [CNT_W-1:0] LAST_COL = CNT_W'(IMG_WIDTH - 1);
	localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(IMG_HEIGHT - 1);

	// Configuration registers.
	logic               show_raw_q;
	logic [DEPTH_W-1:0] front_limit_q;
	logic [DEPTH_W-1:0] back_at_top_q;
	logic [DEPTH_W-1:0] back_at_bottom_q;
	logic [CNT_W-1:0]   crop_left_q;
	logic [CNT_W-1:0]   crop_right_q;
	logic [CNT_W-1:0]   crop_top_q;
	logic [CNT_W-1:0]   crop_bottom_q;

	// Raster position and the far limit of the current row.
	logic [CNT_W-1:0]   col_q;
	logic [CNT_W-1:0]   row_q;
	logic [DEPTH_W-1:0] row_far_q;

	// Stage valid bits and enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic pix_acc;

	// Stage 1: input register.
	logic [DEPTH_W-1:0]   mm_s1;
	logic [FAR_NUM_W-1:0] num_s1;
	logic                 win_ok_s1;
	logic                 x0_s1;
	logic                 fe_s1;

	// Stage 2: far limit product.
	logic [DEPTH_W-1:0]    mm_s2;
	logic [FAR_PROD_W-1:0] far_prod_s2;
	logic                  win_ok_s2;
	logic                  x0_s2;
	logic                  fe_s2;

	// Stage 3: decision and distance magnitude.
	logic [DEPTH_W-1:0] mm_s3;
	logic [DEPTH_W-1:0] mag_s3;
	logic               neg_s3;
	logic               kept_s3;
	logic               fe_s3;

	// Stage 4: divide-by-ten product.
	logic [DEPTH_W-1:0]     mm_s4;
	logic [GREY_PROD_W-1:0] grey_prod_s4;
	logic                   neg_s4;
	logic                   kept_s4;
	logic                   fe_s4;

	// Stage 5: output register.
	res_t res_s5;

	// Combinational values.
	logic signed [NUM_W-1:0]   top_term;
	logic signed [DEPTH_W:0]   span;
	logic signed [SLOPE_W-1:0] slope_term;
	logic signed [NUM_W-1:0]   num_full;
	logic                      win_ok;
	logic [DEPTH_W-1:0]        far_new;
	logic [DEPTH_W-1:0]        far_row;
	logic                      kept;
	logic                      neg;
	logic [DEPTH_W-1:0]        mag;
	logic [GREY_W-1:0]         quot;
	logic [GREY_W-1:0]         grey;

	// Backpressure chain: a stage moves when it is empty or its successor moves.
	always_comb begin
		en5       = !v_s5 || res_ready;
		en4       = !v_s4 || en5;
		en3       = !v_s3 || en4;
		en2       = !v_s2 || en3;
		en1       = !v_s1 || en2;
		pix_ready = en1;
		pix_acc   = pix_valid && en1;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_raw_q       <= 1'b0;
			front_limit_q    <= '0;
			back_at_top_q    <= BACK_LIMIT_RST;
			back_at_bottom_q <= BACK_LIMIT_RST;
			crop_left_q      <= '0;
			crop_right_q     <= CROP_MAX_RST;
			crop_top_q       <= '0;
			crop_bottom_q    <= CROP_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHOW_RAW:       show_raw_q       <= cfg_data[0];
				REG_FRONT_LIMIT:    front_limit_q    <= cfg_data[DEPTH_W-1:0];
				REG_BACK_AT_TOP:    back_at_top_q    <= cfg_data[DEPTH_W-1:0];
				REG_BACK_AT_BOTTOM: back_at_bottom_q <= cfg_data[DEPTH_W-1:0];
				REG_CROP_LEFT:      crop_left_q      <= cfg_data[CNT_W-1:0];
				REG_CROP_RIGHT:     crop_right_q     <= cfg_data[CNT_W-1:0];
				REG_CROP_TOP:       crop_top_q       <= cfg_data[CNT_W-1:0];
				REG_CROP_BOTTOM:    crop_bottom_q    <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	// Column and row counters advance on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (col_q == LAST_COL) begin
				col_q <= '0;
				row_q <= (row_q == LAST_ROW) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Far limit numerator for the current row and the window and confidence test.
	always_comb begin
		top_term   = signed'(NUM_W'(back_at_top_q)) * signed'(NUM_W'(IMG_HEIGHT));
		span       = signed'({1'b0, back_at_bottom_q}) - signed'({1'b0, back_at_top_q});
		slope_term = span * signed'({1'b0, row_q});
		num_full   = top_term + NUM_W'(slope_term);
		win_ok     = (col_q >= crop_left_q) && (col_q <= crop_right_q)
			&& (row_q >= crop_top_q) && (row_q <= crop_bottom_q)
			&& (pix.conf_value >= CONF_W'(MIN_CONFIDENCE));
	end

	// Far limit of a new row, the keep decision and the distance to the far limit.
	always_comb begin
		far_new = far_prod_s2[FAR_SH +: DEPTH_W];
		far_row = x0_s2 ? far_new : row_far_q;
		kept    = show_raw_q || ((mm_s2 != '0) && (mm_s2 >= front_limit_q)
			&& (mm_s2 <= far_row) && win_ok_s2);
		neg     = mm_s2 > far_row;
		mag     = neg ? (mm_s2 - far_row) : (far_row - mm_s2);
	end

	// Grey level: zero for a rejected pixel, else 255 minus (far limit minus depth) divided by ten, wrapped to eight bits.
	always_comb begin
		quot = grey_prod_s4[GREY_SH +: GREY_W];
		if (!kept_s4) begin
			grey = '0;
		end else if (neg_s4) begin
			grey = GREY_W'(GREY_TOP) + quot;
		end else begin
			grey = GREY_W'(GREY_TOP) - quot;
		end
	end

	// Stage valid bits and the per-row far limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			row_far_q <= BACK_LIMIT_RST;
		end else begin
			if (en1) v_s1 <= pix_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en3 && v_s2 && x0_s2) row_far_q <= far_new;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en1) begin
			mm_s1     <= pix.depth_value;
			num_s1    <= num_full[FAR_NUM_W-1:0];
			win_ok_s1 <= win_ok;
			x0_s1     <= (col_q == '0);
			fe_s1     <= (col_q == LAST_COL) && (row_q == LAST_ROW);
		end
		if (en2) begin
			mm_s2       <= mm_s1;
			far_prod_s2 <= num_s1 * FAR_RECIP;
			win_ok_s2   <= win_ok_s1;
			x0_s2       <= x0_s1;
			fe_s2       <= fe_s1;
		end
		if (en3) begin
			mm_s3   <= mm_s2;
			mag_s3  <= mag;
			neg_s3  <= neg;
			kept_s3 <= kept;
			fe_s3   <= fe_s2;
		end
		if (en4) begin
			mm_s4        <= mm_s3;
			grey_prod_s4 <= mag_s3 * GREY_RECIP;
			neg_s4       <= neg_s3;
			kept_s4      <= kept_s3;
			fe_s4        <= fe_s3;
		end
		if (en5) begin
			res_s5.depth_out  <= mm_s4;
			res_s5.grey_level <= grey;
			res_s5.mask_on    <= kept_s4;
			res_s5.frame_end  <= fe_s4;
		end
	end

	assign res_valid = v_s5;
	assign res       = res_s5;

`include "depth_window_threshold_macros.svh"

	// The raster position never leaves the image.
	`DWT_CHECK(a_pos_in_image, (col_q <= LAST_COL) && (row_q <= LAST_ROW), "position out of image")

	// Accepting the last pixel of a frame returns the raster to its origin.
	`DWT_CHECK_NEXT(a_frame_wrap, pix_acc && (col_q == LAST_COL) && (row_q == LAST_ROW), (col_q == '0) && (row_q == '0), "raster did not wrap after frame end")

	// A rejected pixel is always shown black.
	`DWT_CHECK_NOW(a_reject_black, res_valid && !res.mask_on, res.grey_level == '0, "rejected pixel has nonzero grey")

	// With filtering off every result is kept.
	`DWT_CHECK_NOW(a_raw_keeps, res_valid && show_raw_q, res.mask_on, "pixel rejected in raw mode")

endmodule

`default_nettype wire

>>> bench/tb.sv
module tb;
	import dwt_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_LEN    = 400;
	localparam int PHASE_ITEMS = 200;
	localparam int ITEM_TARGET = 2000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   pix_valid = 1'b0;
	logic                   pix_ready;
	pix_t                   pix = '0;
	logic                   res_valid;
	logic                   res_ready = 1'b0;
	res_t                   res;
	logic                   cfg_we = 1'b0;
	cfg_reg_t               cfg_index = REG_SHOW_RAW;
	logic [CFG_W-1:0]       cfg_data = '0;

	// Pixels waiting to be offered and shaded results waiting to come out.
	pix_t                   pixels_to_send[$];
	res_t                   shaded_due[$];
	logic                   pix_accepted = 1'b0;

	// Copy of the register file as last written.
	logic                   raw_mode = 1'b0;
	logic [DEPTH_W-1:0]     front_mm = '0;
	logic [DEPTH_W-1:0]     far_top_mm = BACK_LIMIT_RST;
	logic [DEPTH_W-1:0]     far_bottom_mm = BACK_LIMIT_RST;
	logic [CNT_W-1:0]       win_left = '0;
	logic [CNT_W-1:0]       win_right = CROP_MAX_RST;
	logic [CNT_W-1:0]       win_top = '0;
	logic [CNT_W-1:0]       win_bottom = CROP_MAX_RST;

	// Raster position and far limit of the current row.
	int unsigned            col_pos = 0;
	int unsigned            row_pos = 0;
	logic [DEPTH_W-1:0]     far_mm = BACK_LIMIT_RST;

	// Handshake mix and the long receiver hold-off.
	int unsigned            sender_idle_pct = 0;
	int unsigned            receiver_stall_pct = 0;
	logic                   hold_armed = 1'b0;
	int unsigned            hold_cycles = 0;

	int unsigned            stall_cycles = 0;
	int unsigned            mismatch_count = 0;
	int unsigned            results_checked = 0;
	int unsigned            frames_done = 0;
	int unsigned            items_sent = 0;
	int unsigned            settings_used = 0;

	depth_window_threshold dut (.*);

	always #10 clk = ~clk;

	// Far limit of a row, interpolated from the top and bottom registers.
	function automatic logic [DEPTH_W-1:0] row_far_mm(int unsigned y);
		longint num;
		num = longint'(far_top_mm) * IMG_HEIGHT
			+ (longint'(far_bottom_mm) - longint'(far_top_mm)) * longint'(y);
		if (num < 0)
			num = 0;
		return DEPTH_W'(num / IMG_HEIGHT);
	endfunction

	// Shades one pixel and advances the raster position.
	function automatic res_t shade_pixel(pix_t p);
		res_t        r;
		int unsigned x;
		int unsigned y;
		int          delta;
		int          g;
		logic        keep;
		x = col_pos;
		y = row_pos;
		if (x == 0)
			far_mm = row_far_mm(y);
		keep = 1'b1;
		if (!raw_mode) begin
			if (p.depth_value == 0 || p.depth_value < front_mm || p.depth_value > far_mm)
				keep = 1'b0;
			else if (x < win_left || x > win_right || y < win_top || y > win_bottom)
				keep = 1'b0;
			else if (int'(p.conf_value) < MIN_CONFIDENCE)
				keep = 1'b0;
		end
		r.depth_out = p.depth_value;
		r.grey_level = '0;
		r.mask_on = keep;
		r.frame_end = 1'b0;
		if (keep) begin
			delta = int'(far_mm) - int'(p.depth_value);
			g = GREY_TOP - delta / GREY_STEP;
			r.grey_level = g[GREY_W-1:0];
		end
		if (x + 1 >= IMG_WIDTH) begin
			col_pos = 0;
			if (y + 1 >= IMG_HEIGHT) begin
				row_pos = 0;
				r.frame_end = 1'b1;
			end else begin
				row_pos = y + 1;
			end
		end else begin
			col_pos = x + 1;
		end
		return r;
	endfunction

	// Random pixel, mostly near the edges of the depth window or inside it.
	function automatic pix_t random_pixel();
		pix_t               p;
		int unsigned        r;
		logic [DEPTH_W-1:0] lo;
		logic [DEPTH_W-1:0] hi;
		r = $urandom_range(0, 99);
		lo = (front_mm < far_mm) ? front_mm : far_mm;
		hi = (front_mm < far_mm) ? far_mm : front_mm;
		if (r < 6)
			p.depth_value = '0;
		else if (r < 10)
			p.depth_value = '1;
		else if (r < 18)
			p.depth_value = front_mm + DEPTH_W'($urandom_range(0, 2)) - 1'b1;
		else if (r < 26)
			p.depth_value = far_mm + DEPTH_W'($urandom_range(0, 2)) - 1'b1;
		else if (r < 80)
			p.depth_value = DEPTH_W'($urandom_range(lo, hi));
		else
			p.depth_value = DEPTH_W'($urandom);
		r = $urandom_range(0, 9);
		p.conf_value = (r == 0) ? '0 : (r == 1) ? '1 : CONF_W'($urandom);
		return p;
	endfunction

	task automatic queue_pixel(int unsigned depth, int unsigned conf);
		pix_t p;
		p.depth_value = DEPTH_W'(depth);
		p.conf_value = CONF_W'(conf);
		pixels_to_send = {pixels_to_send, p};
		items_sent++;
	endtask

	// One register write; the copy is updated once the write edge has passed.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SHOW_RAW:       raw_mode = val[0];
			REG_FRONT_LIMIT:    front_mm = val[DEPTH_W-1:0];
			REG_BACK_AT_TOP:    far_top_mm = val[DEPTH_W-1:0];
			REG_BACK_AT_BOTTOM: far_bottom_mm = val[DEPTH_W-1:0];
			REG_CROP_LEFT:      win_left = val[CNT_W-1:0];
			REG_CROP_RIGHT:     win_right = val[CNT_W-1:0];
			REG_CROP_TOP:       win_top = val[CNT_W-1:0];
			REG_CROP_BOTTOM:    win_bottom = val[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Writes all registers: a few fixed extremes first, random settings after.
	task automatic apply_settings(int unsigned k);
		logic [CFG_W-1:0] v [8];
		int               i;
		v[REG_SHOW_RAW] = {15'($urandom), ($urandom_range(0, 5) == 0)};
		v[REG_FRONT_LIMIT] = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom)
			: CFG_W'($urandom_range(0, 2500));
		v[REG_BACK_AT_TOP] = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom)
			: CFG_W'($urandom_range(0, 12000));
		v[REG_BACK_AT_BOTTOM] = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom)
			: CFG_W'($urandom_range(0, 12000));
		v[REG_CROP_LEFT] = {6'($urandom), CNT_W'($urandom_range(0, 40))};
		v[REG_CROP_RIGHT] = {6'($urandom), CNT_W'($urandom_range(250, 1023))};
		v[REG_CROP_TOP] = {6'($urandom), CNT_W'($urandom_range(0, row_pos + 4))};
		v[REG_CROP_BOTTOM] = {6'($urandom), CNT_W'(row_pos + $urandom_range(0, 300))};
		case (k)
			0: begin
				v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1023, 16'd0, 16'd1023};
			end
			1: begin
				v = '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1023, 16'd0, 16'd1023};
			end
			2: begin
				// Far limit falling down the frame, and a crop window with no columns.
				v = '{16'd0, 16'd100, 16'hFFFF, 16'd0, 16'd1023, 16'd0, 16'd0, 16'd1023};
			end
			3: begin
				v[REG_SHOW_RAW] = 16'd1;
				v[REG_BACK_AT_TOP] = 16'd0;
				v[REG_BACK_AT_BOTTOM] = 16'hFFFF;
			end
			4: begin
				v = '{16'd0, 16'd200, 16'd500, 16'd9000, 16'd10, 16'd310, 16'd1, 16'd1023};
			end
			default: ;
		endcase
		for (i = 0; i < 8; i++)
			write_reg(cfg_reg_t'(i), v[i]);
		settings_used++;
	endtask

	task automatic set_idling(int unsigned m);
		case (m)
			0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
			1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
			default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
		endcase
	endtask

	// Waits until every queued pixel has come back, then lets the pipeline settle.
	task automatic drain();
		while (pixels_to_send.size() != 0 || pix_valid || shaded_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic flag_result(string what, res_t want, res_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: expected depth %0d grey %0d mask %0b end %0b, got depth %0d grey %0d mask %0b end %0b",
				what, want.depth_out, want.grey_level, want.mask_on, want.frame_end,
				got.depth_out, got.grey_level, got.mask_on, got.frame_end);
	endtask

	// Pixel driver: offers the next queued item once the current one is taken.
	always @(negedge clk) begin
		if (arst_n && (!pix_valid || pix_accepted)) begin
			if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				pix <= pixels_to_send.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off when armed.
	always @(negedge clk) begin
		if (hold_armed && hold_cycles < HOLD_LEN) begin
			res_ready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Each accepted pixel is shaded into the list of results due.
	always @(posedge clk) begin
		pix_accepted <= arst_n && pix_valid && pix_ready;
		if (arst_n && pix_valid && pix_ready)
			shaded_due = {shaded_due, shade_pixel(pix)};
	end

	// Each accepted result is checked against the oldest one due.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (shaded_due.size() == 0) begin
				flag_result("result with nothing pending", '0, res);
			end else begin
				want = shaded_due.pop_front();
				results_checked++;
				if (res.frame_end === 1'b1)
					frames_done++;
				if (res.depth_out !== want.depth_out || res.grey_level !== want.grey_level
						|| res.mask_on !== want.mask_on || res.frame_end !== want.frame_end)
					flag_result("result mismatch", want, res);
			end
		end
	end

	// Watchdog on cycles with no item moving on either channel.
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (res_valid && res_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", stall_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned m;
		int unsigned s;
		int unsigned chunk;
		int unsigned k;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed pixels on row zero with the reset registers.
		queue_pixel(0, 0);
		queue_pixel(1, 65535);
		queue_pixel(3999, 16'h5555);
		queue_pixel(4000, 16'hAAAA);
		queue_pixel(4001, 1);
		queue_pixel(65535, 65535);
		queue_pixel(3990, 16'h8000);
		queue_pixel(2455, 16'h7FFF);
		drain();

		// Front limit edges.
		write_reg(REG_FRONT_LIMIT, 16'd3000);
		queue_pixel(2999, 5);
		queue_pixel(3000, 6);
		queue_pixel(0, 7);
		drain();

		// Raw mode keeps everything, including depths past the far limit.
		write_reg(REG_SHOW_RAW, 16'd1);
		queue_pixel(0, 0);
		queue_pixel(65535, 65535);
		queue_pixel(4010, 3);
		queue_pixel(4009, 4);
		drain();

		// Empty crop window, then far limit moved in the middle of a row.
		write_reg(REG_SHOW_RAW, 16'd0);
		write_reg(REG_CROP_LEFT, 16'd1023);
		write_reg(REG_CROP_RIGHT, 16'd0);
		queue_pixel(3500, 9);
		drain();
		write_reg(REG_CROP_LEFT, 16'd0);
		write_reg(REG_CROP_RIGHT, 16'd1023);
		write_reg(REG_BACK_AT_TOP, 16'd100);
		queue_pixel(3500, 10);
		queue_pixel(3500, 11);
		drain();

		// Random pixels under each handshake mix, two register settings per mix.
		k = 0;
		for (m = 0; m < 4; m++) begin
			set_idling(m);
			for (s = 0; s < 2; s++) begin
				apply_settings(k);
				k++;
				if (m == 0 && s == 0)
					hold_armed = 1'b1;
				repeat (PHASE_ITEMS) begin
					pixels_to_send = {pixels_to_send, random_pixel()};
					items_sent++;
				end
				drain();
			end
		end

		// Finish with short chunks that change the registers at arbitrary
		// points of a row.
		m = 0;
		while (items_sent < ITEM_TARGET) begin
			set_idling(m % 4);
			m++;
			apply_settings(k);
			k++;
			chunk = $urandom_range(40, 150);
			if (chunk > ITEM_TARGET - items_sent)
				chunk = ITEM_TARGET - items_sent;
			repeat (chunk) begin
				pixels_to_send = {pixels_to_send, random_pixel()};
				items_sent++;
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Covered %0d pixels, %0d frame ends, %0d register settings, four handshake mixes.",
			items_sent, frames_done, settings_used);
		$display("Compared %0d results; %0d mismatches, %0d results still pending.",
			results_checked, mismatch_count, shaded_due.size());
		if (mismatch_count == 0 && shaded_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
